// ===== rtl/core/aes128_pkg.sv =====
package aes128_pkg;

	typedef struct packed {
		logic        mode;
		logic [63:0] data_high;
		logic [63:0] data_low;
	} in_req_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} out_req_t;

	localparam int NUM_ROUNDS = 10;
	localparam int RK_DEPTH   = NUM_ROUNDS + 1;
	localparam int RK_AW      = 4;

	localparam logic CFG_KEY_LOW  = 1'b0;
	localparam logic CFG_KEY_HIGH = 1'b1;

	typedef struct packed {
		logic        load;
		logic        round;
		logic        unload;
		logic        decrypt;
		logic        first;
		logic        last;
		logic [RK_AW-1:0] rk_addr;
		logic        kx_start;
		logic        kx_step;
		logic [RK_AW-1:0] kx_addr;
		logic        kx_write;
	} dp_cmd_t;

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = 8'h00;
		x = a;
		for (int i = 0; i < 4; i++) begin
			if (b[i]) p = p ^ x;
			x = xt(x);
		end
		return p;
	endfunction

	function automatic logic [7:0] gmul8(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p = p ^ x;
			x = xt(x);
		end
		return p;
	endfunction

	function automatic logic [7:0] ginv(input logic [7:0] x);
		logic [7:0] r;
		logic [7:0] b;
		r = 8'h01;
		b = x;
		for (int i = 0; i < 8; i++) begin
			if (i != 0) r = gmul8(r, b);
			b = gmul8(b, b);
		end
		return r;
	endfunction

	function automatic logic [7:0] rotl(input logic [7:0] v, input int n);
		return (v << n) | (v >> (8 - n));
	endfunction

	function automatic logic [7:0] sbox_f(input logic [7:0] x);
		logic [7:0] v;
		v = ginv(x);
		return v ^ rotl(v, 1) ^ rotl(v, 2) ^ rotl(v, 3) ^ rotl(v, 4) ^ 8'h63;
	endfunction

	function automatic logic [7:0] isbox_f(input logic [7:0] y);
		return ginv(rotl(y, 1) ^ rotl(y, 3) ^ rotl(y, 6) ^ 8'h05);
	endfunction

	typedef logic [7:0] sbox_tab_t [256];

	function automatic sbox_tab_t mk_sbox(input logic inv);
		sbox_tab_t t;
		for (int i = 0; i < 256; i++) t[i] = inv ? isbox_f(8'(i)) : sbox_f(8'(i));
		return t;
	endfunction

	localparam sbox_tab_t SBOX  = mk_sbox(1'b0);
	localparam sbox_tab_t ISBOX = mk_sbox(1'b1);

	function automatic logic [7:0] rcon(input logic [3:0] r);
		logic [7:0] v;
		case (r)
			4'd1: v = 8'h01;
			4'd2: v = 8'h02;
			4'd3: v = 8'h04;
			4'd4: v = 8'h08;
			4'd5: v = 8'h10;
			4'd6: v = 8'h20;
			4'd7: v = 8'h40;
			4'd8: v = 8'h80;
			4'd9: v = 8'h1b;
			4'd10: v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/core/aes128_block_cipher_unit.sv =====
// AES-128 encrypt/decrypt of one 128-bit block per request. After the request
// is accepted the block goes through the first key addition, then each round in
// a single shared round unit, and is then moved into the output register. A new
// request is accepted the cycle after the block moves out, so the unit takes no
// new request while one is in flight; a result held by a stalled receiver keeps
// the following block from moving out, which holds off the next request. After
// reset or any key write, the eleven round keys are expanded one per cycle
// before the next request is accepted. Write keys only while idle.
module aes128_block_cipher_unit
	import aes128_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_req_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_req_t    out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_wdata
);

	logic [63:0] key_lo_q;
	logic [63:0] key_hi_q;
	dp_cmd_t cmd;
	logic [127:0] dout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q <= '0;
			key_hi_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_LOW:  key_lo_q <= cfg_wdata;
				CFG_KEY_HIGH: key_hi_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	aes128_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_mode(in_data.mode), .out_valid(out_valid), .out_stall(out_stall),
		.key_wr(cfg_we), .cmd(cmd)
	);

	aes128_dp u_dp (
		.clk(clk), .cmd(cmd), .key({key_hi_q, key_lo_q}),
		.din({in_data.data_high, in_data.data_low}), .dout(dout)
	);

	assign out_data.result_low  = dout[63:0];
	assign out_data.result_high = dout[127:64];

	property p_out_stable;
		@(posedge clk) disable iff (!arst_n) out_valid && out_stall |=> $stable(out_data);
	endproperty
	assert property (p_out_stable) else $error("stalled result changed");

	property p_done_holds;
		@(posedge clk) disable iff (!arst_n) out_valid && out_stall |=> out_valid;
	endproperty
	assert property (p_done_holds) else $error("result dropped");

endmodule

// ===== rtl/core/aes128_ctrl.sv =====
module aes128_ctrl
	import aes128_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic      in_mode,
	output logic      out_valid,
	input  logic      out_stall,
	input  logic      key_wr,
	output dp_cmd_t   cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_KEXP = 4'b0010,
		ST_RUN  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;
	logic stale_q;
	logic dec_q;
	logic ovld_q;
	logic [RK_AW-1:0] cnt_q;
	logic rd_ok;
	logic [RK_AW-1:0] rd_addr;

	localparam logic [RK_AW-1:0] LAST = RK_AW'(NUM_ROUNDS);

	assign in_stall  = !(state_q == ST_IDLE && !stale_q);
	assign out_valid = ovld_q;

	always_comb begin
		rd_addr = '0;
		if (state_q == ST_IDLE) begin
			rd_addr = in_mode ? LAST : '0;
		end else if (state_q == ST_RUN && cnt_q != LAST) begin
			rd_addr = dec_q ? LAST - cnt_q - RK_AW'(1) : cnt_q + RK_AW'(1);
		end
		rd_ok = 1'b1;
	end

	always_comb begin
		cmd          = '0;
		cmd.decrypt  = dec_q;
		cmd.rk_addr  = rd_addr;
		cmd.load     = state_q == ST_IDLE && !stale_q && in_valid && rd_ok;
		cmd.round    = state_q == ST_RUN;
		cmd.unload   = state_q == ST_DONE && (!ovld_q || !out_stall);
		cmd.first    = state_q == ST_RUN && cnt_q == '0;
		cmd.last     = state_q == ST_RUN && cnt_q == LAST;
		cmd.kx_start = state_q == ST_IDLE && stale_q;
		cmd.kx_step  = state_q == ST_KEXP;
		cmd.kx_write = state_q == ST_KEXP;
		cmd.kx_addr  = cnt_q;
		if (cmd.load) cmd.decrypt = in_mode;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (cmd.unload) begin
			ovld_q <= 1'b1;
		end else if (!out_stall) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stale_q <= 1'b1;
			dec_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (key_wr) stale_q <= 1'b1;
			unique case (state_q)
				ST_IDLE: begin
					if (stale_q) begin
						state_q <= ST_KEXP;
						cnt_q   <= RK_AW'(1);
					end else begin
						cnt_q <= '0;
						if (in_valid) begin
							dec_q   <= in_mode;
							state_q <= ST_RUN;
						end
					end
				end
				ST_KEXP: begin
					cnt_q <= cnt_q + RK_AW'(1);
					if (cnt_q == LAST) begin
						state_q <= ST_IDLE;
						if (!key_wr) stale_q <= 1'b0;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + RK_AW'(1);
					if (cnt_q == LAST) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!ovld_q || !out_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/aes128_dp.sv =====
module aes128_dp
	import aes128_pkg::*;
(
	input  logic          clk,
	input  dp_cmd_t       cmd,
	input  logic [127:0]  key,
	input  logic [127:0]  din,
	output logic [127:0]  dout
);

	logic [127:0] rk_mem [RK_DEPTH];
	logic [127:0] rk_q;
	logic [127:0] kx_q;
	logic [127:0] st_q;
	logic [127:0] res_q;
	logic [127:0] kx_nxt;
	logic [127:0] rnd;
	logic [127:0] sr;
	logic [127:0] sb;
	logic [127:0] mc;
	logic [31:0]  tw;

	always_comb begin
		tw = {SBOX[kx_q[103:96]], SBOX[kx_q[127:120]], SBOX[kx_q[119:112]],
			SBOX[kx_q[111:104]] ^ rcon(cmd.kx_addr)};
		kx_nxt[31:0]   = kx_q[31:0] ^ tw;
		kx_nxt[63:32]  = kx_q[63:32] ^ kx_nxt[31:0];
		kx_nxt[95:64]  = kx_q[95:64] ^ kx_nxt[63:32];
		kx_nxt[127:96] = kx_q[127:96] ^ kx_nxt[95:64];
	end

	always_ff @(posedge clk) begin
		if (cmd.kx_start) begin
			kx_q      <= key;
			rk_mem[0] <= key;
		end else if (cmd.kx_step) begin
			kx_q <= kx_nxt;
			if (cmd.kx_write) rk_mem[cmd.kx_addr] <= kx_nxt;
		end
		rk_q <= rk_mem[cmd.rk_addr];
	end

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				sr[8*(r+4*c) +: 8] = cmd.decrypt ? st_q[8*(r+4*((c-r+4)&3)) +: 8]
					: st_q[8*(r+4*((c+r)&3)) +: 8];
			end
		end
		for (int i = 0; i < 16; i++) begin
			sb[8*i +: 8] = cmd.decrypt ? ISBOX[sr[8*i +: 8]] : SBOX[sr[8*i +: 8]];
		end
		if (cmd.decrypt) begin
			sb = sb ^ rk_q;
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (cmd.decrypt)
					mc[8*(4*c+r) +: 8] = gmul(sb[8*(4*c+r) +: 8], 4'd14)
						^ gmul(sb[8*(4*c+((r+1)&3)) +: 8], 4'd11)
						^ gmul(sb[8*(4*c+((r+2)&3)) +: 8], 4'd13)
						^ gmul(sb[8*(4*c+((r+3)&3)) +: 8], 4'd9);
				else
					mc[8*(4*c+r) +: 8] = gmul(sb[8*(4*c+r) +: 8], 4'd2)
						^ gmul(sb[8*(4*c+((r+1)&3)) +: 8], 4'd3)
						^ sb[8*(4*c+((r+2)&3)) +: 8]
						^ sb[8*(4*c+((r+3)&3)) +: 8];
			end
		end
		if (cmd.last) rnd = sb;
		else rnd = mc;
		if (!cmd.decrypt) rnd = rnd ^ rk_q;
		if (cmd.first) rnd = st_q ^ rk_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) st_q <= din;
		else if (cmd.round) st_q <= rnd;
	end

	always_ff @(posedge clk) begin
		if (cmd.unload) res_q <= st_q;
	end

	assign dout = res_q;

endmodule

// ===== test/testbench.sv =====
module testbench
	import aes128_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int RANDOM_BLOCKS  = 800;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_req_t     in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_req_t    out_data;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_KEY_LOW;
	logic [63:0] cfg_wdata = '0;

	aes128_block_cipher_unit uut (.*);

	always #2 clk = ~clk;

	typedef struct {
		in_req_t     req;
		logic        has_known;
		logic [63:0] known_low;
		logic [63:0] known_high;
	} vector_t;

	typedef logic [7:0] block_t [16];

	logic [63:0] key_lo_q = '0;
	logic [63:0] key_hi_q = '0;
	logic [63:0] sched [22];
	logic [7:0]  fwd_box [256];
	logic [7:0]  inv_box [256];
	out_req_t    pending_blocks [$];
	int          failures = 0;
	int          idle_cycles = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic        hold_off = 1'b0;
	logic        watchdog_fired = 1'b0;

	function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
		end
		return p;
	endfunction

	function automatic logic [7:0] gf_recip(input logic [7:0] x);
		logic [7:0] r;
		r = 8'h01;
		for (int i = 0; i < 254; i++) r = gf_times(r, x);
		return x == 8'h00 ? 8'h00 : r;
	endfunction

	function automatic logic [7:0] rot8(input logic [7:0] v, input int n);
		return (v << n) | (v >> (8 - n));
	endfunction

	task automatic build_boxes();
		logic [7:0] v;
		for (int i = 0; i < 256; i++) begin
			v = gf_recip(8'(i));
			fwd_box[i] = v ^ rot8(v, 1) ^ rot8(v, 2) ^ rot8(v, 3) ^ rot8(v, 4) ^ 8'h63;
		end
		for (int i = 0; i < 256; i++) inv_box[fwd_box[i]] = 8'(i);
	endtask

	function automatic block_t split_block(input logic [63:0] lo, input logic [63:0] hi);
		block_t b;
		for (int i = 0; i < 8; i++) begin
			b[i] = lo[8*i +: 8];
			b[8+i] = hi[8*i +: 8];
		end
		return b;
	endfunction

	task automatic expand_schedule();
		logic [7:0] w [176];
		logic [7:0] t [4];
		logic [7:0] t0;
		logic [7:0] rc;
		block_t k;
		k = split_block(key_lo_q, key_hi_q);
		for (int i = 0; i < 16; i++) w[i] = k[i];
		rc = 8'h01;
		for (int i = 4; i < 44; i++) begin
			for (int j = 0; j < 4; j++) t[j] = w[4*(i-1)+j];
			if ((i & 3) == 0) begin
				t0 = t[0];
				t[0] = fwd_box[t[1]] ^ rc;
				t[1] = fwd_box[t[2]];
				t[2] = fwd_box[t[3]];
				t[3] = fwd_box[t0];
				rc = gf_times(rc, 8'h02);
			end
			for (int j = 0; j < 4; j++) w[4*i+j] = w[4*(i-4)+j] ^ t[j];
		end
		for (int i = 0; i < 22; i++)
			for (int j = 0; j < 8; j++) sched[i][8*j +: 8] = w[8*i+j];
	endtask

	function automatic block_t mix_round_key(input block_t s, input int r);
		block_t k;
		k = split_block(sched[2*r], sched[2*r+1]);
		for (int i = 0; i < 16; i++) s[i] ^= k[i];
		return s;
	endfunction

	function automatic block_t shift_block(input block_t s, input logic inverse);
		block_t t;
		int src;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				src = inverse ? ((c - r + 4) & 3) : ((c + r) & 3);
				t[r + 4*c] = s[r + 4*src];
			end
		return t;
	endfunction

	function automatic block_t mix_block(input block_t s, input logic inverse);
		logic [7:0] m [4];
		logic [7:0] a [4];
		logic [7:0] v;
		if (inverse) m = '{8'd14, 8'd11, 8'd13, 8'd9};
		else m = '{8'd2, 8'd3, 8'd1, 8'd1};
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) a[r] = s[4*c+r];
			for (int r = 0; r < 4; r++) begin
				v = 8'h00;
				for (int k = 0; k < 4; k++) v ^= gf_times(m[(k - r + 4) & 3], a[k]);
				s[4*c+r] = v;
			end
		end
		return s;
	endfunction

	function automatic out_req_t cipher_block(input in_req_t req);
		block_t s;
		out_req_t o;
		s = split_block(req.data_low, req.data_high);
		if (!req.mode) begin
			s = mix_round_key(s, 0);
			for (int r = 1; r <= NUM_ROUNDS; r++) begin
				for (int i = 0; i < 16; i++) s[i] = fwd_box[s[i]];
				s = shift_block(s, 1'b0);
				if (r != NUM_ROUNDS) s = mix_block(s, 1'b0);
				s = mix_round_key(s, r);
			end
		end else begin
			s = mix_round_key(s, NUM_ROUNDS);
			for (int r = NUM_ROUNDS - 1; r >= 0; r--) begin
				s = shift_block(s, 1'b1);
				for (int i = 0; i < 16; i++) s[i] = inv_box[s[i]];
				s = mix_round_key(s, r);
				if (r != 0) s = mix_block(s, 1'b1);
			end
		end
		for (int i = 0; i < 8; i++) begin
			o.result_low[8*i +: 8] = s[i];
			o.result_high[8*i +: 8] = s[8+i];
		end
		return o;
	endfunction

	task automatic send_block(input in_req_t req);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_blocks.push_back(cipher_block(req));
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_blocks.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_key(input logic idx, input logic [63:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_KEY_LOW) key_lo_q = value;
		else key_hi_q = value;
		expand_schedule();
	endtask

	function automatic in_req_t random_block();
		in_req_t r;
		r.mode = 1'($urandom_range(1));
		r.data_low = {$urandom, $urandom};
		r.data_high = {$urandom, $urandom};
		return r;
	endfunction

	always @(negedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_blocks.size() == 0) begin
				$display("%0t: unexpected block %h", $realtime, out_data);
				failures++;
			end else begin
				if (out_data.result_low !== pending_blocks[0].result_low) begin
					$display("%0t: result_low expected %h actual %h", $realtime,
						pending_blocks[0].result_low, out_data.result_low);
					failures++;
				end
				if (out_data.result_high !== pending_blocks[0].result_high) begin
					$display("%0t: result_high expected %h actual %h", $realtime,
						pending_blocks[0].result_high, out_data.result_high);
					failures++;
				end
				void'(pending_blocks.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !watchdog_fired) begin
			watchdog_fired = 1'b1;
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		vector_t directed [$];
		vector_t v;
		out_req_t got;
		int pcts [4][2];
		pcts = '{'{0, 0}, '{75, 0}, '{0, 75}, '{27, 27}};
		build_boxes();
		expand_schedule();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Known answers: all-zero key after reset, then the standard example key.
		directed.push_back('{'{1'b0, 64'h0, 64'h0}, 1'b1,
			64'h3b2c8aefd44be966, 64'h2e2b34ca59fa4c88});
		directed.push_back('{'{1'b1, 64'h2e2b34ca59fa4c88, 64'h3b2c8aefd44be966}, 1'b1,
			64'h0, 64'h0});
		directed.push_back('{'{1'b0, '1, '1}, 1'b0, '0, '0});
		directed.push_back('{'{1'b1, '1, '1}, 1'b0, '0, '0});
		directed.push_back('{'{1'b0, 64'h0, '1}, 1'b0, '0, '0});
		directed.push_back('{'{1'b1, '1, 64'h0}, 1'b0, '0, '0});
		foreach (directed[i]) begin
			v = directed[i];
			send_block(v.req);
			if (v.has_known) begin
				got.result_low = v.known_low;
				got.result_high = v.known_high;
				if (got !== pending_blocks[$]) begin
					$display("%0t: known answer expected %h actual %h", $realtime,
						got, pending_blocks[$]);
					failures++;
				end
			end
		end

		write_key(CFG_KEY_LOW, 64'h0706050403020100);
		write_key(CFG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
		send_block('{1'b0, 64'hffeeddccbbaa9988, 64'h7766554433221100});
		got = '{64'h5ac5b47080b7cdd8, 64'h30047b6ad8e0c469};
		if (pending_blocks[$] !== got) begin
			$display("%0t: known answer expected %h actual %h", $realtime,
				got, pending_blocks[$]);
			failures++;
		end
		send_block('{1'b1, 64'h5ac5b47080b7cdd8, 64'h30047b6ad8e0c469});
		got = '{64'hffeeddccbbaa9988, 64'h7766554433221100};
		if (pending_blocks[$] !== got) begin
			$display("%0t: known answer expected %h actual %h", $realtime,
				got, pending_blocks[$]);
			failures++;
		end
		write_key(CFG_KEY_LOW, '1);
		write_key(CFG_KEY_HIGH, '1);
		send_block('{1'b0, 64'h0, 64'h0});
		send_block('{1'b1, '1, '1});

		drain();
		hold_off = 1'b1;
		fork
			begin
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 6; i++) send_block(random_block());
		join

		for (int phase = 0; phase < 8; phase++) begin
			send_idle_pct = pcts[phase % 4][0];
			recv_stall_pct = pcts[phase % 4][1];
			if (phase != 0) write_key(1'($urandom_range(1)), {$urandom, $urandom});
			if (phase == 4) write_key(CFG_KEY_LOW, '0);
			if (phase == 4) write_key(CFG_KEY_HIGH, '0);
			for (int i = 0; i < RANDOM_BLOCKS / 8; i++) send_block(random_block());
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();

		if (failures == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end
endmodule
